// ----- rtl/bpm_pkg.sv -----
package bpm_pkg;

    localparam int NUM_KINDS = 3;
    localparam int NUM_CFG_REGS = 6;
    localparam int RESULT_CAP = 50;
    localparam int FCNT_W = $clog2(RESULT_CAP);

    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_BRACE  = 2'd2;

    localparam logic [2:0] EV_PAIR     = 3'd0;
    localparam logic [2:0] EV_UNCLOSE  = 3'd1;
    localparam logic [2:0] EV_UNOPEN   = 3'd2;
    localparam logic [2:0] EV_OVERFLOW = 3'd3;
    localparam logic [2:0] EV_END      = 3'd4;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_OPEN  = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;

    typedef logic [7:0] t_char;
    typedef t_char [NUM_CFG_REGS-1:0] t_char_set;

    localparam t_char_set CHAR_RESET = {8'd125, 8'd123, 8'd93, 8'd91, 8'd41, 8'd40};

    typedef logic [NUM_KINDS-1:0][1:0] t_act_vec;

    typedef struct packed {
        logic     flush;
        t_act_vec act;
    } t_cmd;

endpackage

// ----- rtl/bpm_front.sv -----
module bpm_front #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic                  i_single,
    input  logic [7:0]            i_char,
    input  logic                  i_full,
    output logic                  o_push,
    output bpm_pkg::t_cmd         o_cmd,
    output logic [INDEX_BITS-1:0] o_idx
);

    bpm_pkg::t_char_set    r_chars;
    logic [INDEX_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= bpm_pkg::CHAR_RESET;
        end else if (i_cfg_we) begin
            for (int i = 0; i < bpm_pkg::NUM_CFG_REGS; i++) begin
                if (i_cfg_idx == 3'(i)) begin
                    r_chars[i] <= i_cfg_data;
                end
            end
        end
    end

    // open wins when a kind's open and close codes are equal
    always_comb begin
        o_cmd.flush = i_mode;
        for (int k = 0; k < bpm_pkg::NUM_KINDS; k++) begin
            if (i_mode || !i_single) begin
                o_cmd.act[k] = bpm_pkg::ACT_NONE;
            end else if (i_char == r_chars[2*k]) begin
                o_cmd.act[k] = bpm_pkg::ACT_OPEN;
            end else if (i_char == r_chars[2*k+1]) begin
                o_cmd.act[k] = bpm_pkg::ACT_CLOSE;
            end else begin
                o_cmd.act[k] = bpm_pkg::ACT_NONE;
            end
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_idx   = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            if (i_mode) begin
                r_count <= '0;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/bpm_fifo.sv -----
module bpm_fifo #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/bpm_back.sv -----
module bpm_back #(
    parameter int STACK_DEPTH = 16,
    parameter int INDEX_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  bpm_pkg::t_cmd         i_cmd,
    input  logic [INDEX_BITS-1:0] i_idx,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_kind,
    output logic [2:0]            o_event,
    output logic [15:0]           o_open,
    output logic [15:0]           o_close,
    output logic                  o_last
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [LW-1:0] FULL_LVL = LW'(STACK_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TOK   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic [INDEX_BITS-1:0] r_stk0 [STACK_DEPTH];
    logic [INDEX_BITS-1:0] r_stk1 [STACK_DEPTH];
    logic [INDEX_BITS-1:0] r_stk2 [STACK_DEPTH];

    logic [1:0]                 r_state, n_state;
    bpm_pkg::t_act_vec          r_act, n_act;
    logic [INDEX_BITS-1:0]      r_idx, n_idx;
    logic [LW-1:0]              r_lvl [bpm_pkg::NUM_KINDS];
    logic [LW-1:0]              n_lvl [bpm_pkg::NUM_KINDS];
    logic [1:0]                 r_fkind, n_fkind;
    logic [bpm_pkg::FCNT_W-1:0] r_fcnt, n_fcnt;
    logic                       r_ov, n_ov;
    logic [1:0]                 r_okind, n_okind;
    logic [2:0]                 r_oev, n_oev;
    logic [15:0]                r_oopen, n_oopen;
    logic [15:0]                r_oclose, n_oclose;
    logic                       r_olast, n_olast;

    logic                  out_ok;
    logic [LW-1:0]         top_ptr [bpm_pkg::NUM_KINDS];
    logic [INDEX_BITS-1:0] top_val [bpm_pkg::NUM_KINDS];
    logic [1:0]            cur;
    logic                  has_any;
    logic                  rest_any;
    logic                  rest_res;
    logic                  push_en;
    logic [AW-1:0]         push_addr;

    assign out_ok = !r_ov || i_ready;

    always_comb begin
        for (int k = 0; k < bpm_pkg::NUM_KINDS; k++) begin
            top_ptr[k] = r_lvl[k] - 1'b1;
        end
        top_val[0] = r_stk0[top_ptr[0][AW-1:0]];
        top_val[1] = r_stk1[top_ptr[1][AW-1:0]];
        top_val[2] = r_stk2[top_ptr[2][AW-1:0]];
    end

    // lowest kind still pending, and what remains after it
    always_comb begin
        cur      = bpm_pkg::KIND_PAREN;
        has_any  = 1'b0;
        rest_any = 1'b0;
        rest_res = 1'b0;
        for (int k = bpm_pkg::NUM_KINDS - 1; k >= 0; k--) begin
            if (r_act[k] != bpm_pkg::ACT_NONE) begin
                cur     = 2'(k);
                has_any = 1'b1;
            end
        end
        for (int j = 0; j < bpm_pkg::NUM_KINDS; j++) begin
            if (2'(j) > cur && r_act[j] != bpm_pkg::ACT_NONE) begin
                rest_any = 1'b1;
                if (r_act[j] == bpm_pkg::ACT_CLOSE || r_lvl[j] == FULL_LVL) begin
                    rest_res = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_idx     = r_idx;
        n_lvl     = r_lvl;
        n_fkind   = r_fkind;
        n_fcnt    = r_fcnt;
        n_ov      = r_ov && !i_ready;
        n_okind   = r_okind;
        n_oev     = r_oev;
        n_oopen   = r_oopen;
        n_oclose  = r_oclose;
        n_olast   = r_olast;
        o_pop     = 1'b0;
        push_en   = 1'b0;
        push_addr = r_lvl[cur][AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.flush) begin
                        n_state = ST_FLUSH;
                        n_fkind = bpm_pkg::KIND_PAREN;
                        n_fcnt  = '0;
                    end else begin
                        n_act   = i_cmd.act;
                        n_idx   = i_idx;
                        n_state = ST_TOK;
                    end
                end
            end
            ST_TOK: begin
                if (!has_any) begin
                    n_state = ST_IDLE;
                end else if (r_act[cur] == bpm_pkg::ACT_OPEN && r_lvl[cur] < FULL_LVL) begin
                    push_en    = 1'b1;
                    n_lvl[cur] = r_lvl[cur] + 1'b1;
                    n_act[cur] = bpm_pkg::ACT_NONE;
                    if (!rest_any) begin
                        n_state = ST_IDLE;
                    end
                end else if (out_ok) begin
                    n_ov     = 1'b1;
                    n_okind  = cur;
                    n_oclose = 16'(r_idx);
                    n_oopen  = '0;
                    n_olast  = !rest_res;
                    if (r_act[cur] == bpm_pkg::ACT_OPEN) begin
                        n_oev = bpm_pkg::EV_OVERFLOW;
                    end else if (r_lvl[cur] == '0) begin
                        n_oev = bpm_pkg::EV_UNCLOSE;
                    end else begin
                        n_oev      = bpm_pkg::EV_PAIR;
                        n_oopen    = 16'(top_val[cur]);
                        n_lvl[cur] = top_ptr[cur];
                    end
                    n_act[cur] = bpm_pkg::ACT_NONE;
                    if (!rest_any) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (r_lvl[r_fkind] == '0) begin
                    if (r_fkind == bpm_pkg::KIND_BRACE) begin
                        n_state = ST_END;
                    end else begin
                        n_fkind = r_fkind + 1'b1;
                    end
                end else if (r_fcnt >= bpm_pkg::FCNT_W'(bpm_pkg::RESULT_CAP - 1)) begin
                    n_lvl[r_fkind] = '0;
                end else if (out_ok) begin
                    n_ov           = 1'b1;
                    n_okind        = r_fkind;
                    n_oev          = bpm_pkg::EV_UNOPEN;
                    n_oopen        = 16'(top_val[r_fkind]);
                    n_oclose       = '0;
                    n_olast        = 1'b0;
                    n_fcnt         = r_fcnt + 1'b1;
                    n_lvl[r_fkind] = top_ptr[r_fkind];
                end
            end
            ST_END: begin
                if (out_ok) begin
                    n_ov     = 1'b1;
                    n_okind  = bpm_pkg::KIND_PAREN;
                    n_oev    = bpm_pkg::EV_END;
                    n_oopen  = '0;
                    n_oclose = '0;
                    n_olast  = 1'b1;
                    for (int k = 0; k < bpm_pkg::NUM_KINDS; k++) begin
                        n_lvl[k] = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push_en && cur == bpm_pkg::KIND_PAREN) begin
            r_stk0[push_addr] <= r_idx;
        end
        if (push_en && cur == bpm_pkg::KIND_SQUARE) begin
            r_stk1[push_addr] <= r_idx;
        end
        if (push_en && cur == bpm_pkg::KIND_BRACE) begin
            r_stk2[push_addr] <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_act   <= '0;
            r_fkind <= bpm_pkg::KIND_PAREN;
            r_fcnt  <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < bpm_pkg::NUM_KINDS; k++) begin
                r_lvl[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_fkind <= n_fkind;
            r_fcnt  <= n_fcnt;
            r_ov    <= n_ov;
            r_lvl   <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_okind  <= n_okind;
        r_oev    <= n_oev;
        r_oopen  <= n_oopen;
        r_oclose <= n_oclose;
        r_olast  <= n_olast;
    end

    assign o_valid = r_ov;
    assign o_kind  = r_okind;
    assign o_event = r_oev;
    assign o_open  = r_oopen;
    assign o_close = r_oclose;
    assign o_last  = r_olast;

    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl[0] <= FULL_LVL && r_lvl[1] <= FULL_LVL && r_lvl[2] <= FULL_LVL)
        else $error("stack level above depth");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && out_ok) |=>
        (r_lvl[0] == '0 && r_lvl[1] == '0 && r_lvl[2] == '0 && r_state == ST_IDLE))
        else $error("levels not cleared after end marker");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oev == bpm_pkg::EV_END) |-> (r_olast && r_okind == bpm_pkg::KIND_PAREN))
        else $error("end marker not last or wrong kind");

    a_flush_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= bpm_pkg::FCNT_W'(bpm_pkg::RESULT_CAP - 1))
        else $error("flush result count past cap");

endmodule

// ----- rtl/bracket_pair_matcher_core.sv -----
// result path: a token goes through the command queue, then the back's pop and token steps
// token: the back takes a token's kinds one by one, results waiting on output ready, and pops no
//   command until done; the front keeps taking beats while the 4-entry command queue has room
// flush: one unopened result per leftover opener, kind by kind, then the end marker beat
// reset: synchronous active low; clears levels, token counter, queue, output and
//   restores default bracket codes; stack entries are not cleared
module bracket_pair_matcher_core #(
    parameter int STACK_DEPTH = 16,
    parameter int INDEX_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // is_single_char, char_code, zero pad
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // bracket_kind, event_res, opener_idx, close_index, pad
    output logic        o_m_axis_tlast
);

    localparam int QW = $bits(bpm_pkg::t_cmd) + INDEX_BITS;

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    bpm_pkg::t_cmd         f_cmd;
    logic [INDEX_BITS-1:0] f_idx;
    bpm_pkg::t_cmd         b_cmd;
    logic [INDEX_BITS-1:0] b_idx;
    logic [QW-1:0]         q_out;
    logic [1:0]            b_kind;
    logic [2:0]            b_event;
    logic [15:0]           b_open;
    logic [15:0]           b_close;

    bpm_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_mode     (i_s_axis_tuser),
        .i_single   (i_s_axis_tdata[0]),
        .i_char     (i_s_axis_tdata[8:1]),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (f_cmd),
        .o_idx      (f_idx)
    );

    bpm_fifo #(
        .WIDTH(QW),
        .DEPTH(4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_cmd, f_idx}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign b_cmd = q_out[QW-1:INDEX_BITS];
    assign b_idx = q_out[INDEX_BITS-1:0];

    bpm_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_cmd   (b_cmd),
        .i_idx   (b_idx),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (b_kind),
        .o_event (b_event),
        .o_open  (b_open),
        .o_close (b_close),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, b_close, b_open, b_event, b_kind};

endmodule

// ----- sim/tb_bracket_pair_matcher_core.sv -----
module tb_bracket_pair_matcher_core;

    localparam int STACK_DEPTH = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    localparam logic [2:0] REG_PAREN_OPEN   = 3'd0;
    localparam logic [2:0] REG_PAREN_CLOSE  = 3'd1;
    localparam logic [2:0] REG_SQUARE_OPEN  = 3'd2;
    localparam logic [2:0] REG_SQUARE_CLOSE = 3'd3;
    localparam logic [2:0] REG_BRACE_OPEN   = 3'd4;
    localparam logic [2:0] REG_BRACE_CLOSE  = 3'd5;

    localparam logic MODE_TOKEN = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_LSQUARE = 8'd91;
    localparam logic [7:0] CH_RSQUARE = 8'd93;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;
    localparam logic [7:0] CH_LETTER_A = 8'd97;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  ev;
        logic [15:0] open_idx;
        logic [15:0] close_idx;
        logic        last;
    } t_bracket_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_tdata = '0;    // is_single_char, char_code, zero pad
    logic        s_tuser = 1'b0;  // mode
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_tdata;         // bracket_kind, event_res, opener_idx, close_index, pad
    logic        m_tlast;

    bracket_pair_matcher_core #(
        .STACK_DEPTH(STACK_DEPTH),
        .INDEX_BITS (16)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast)
    );

    // matcher state mirrored in the testbench
    logic [7:0]      bracket_codes [bpm_pkg::NUM_CFG_REGS];
    logic [15:0]     open_stacks [bpm_pkg::NUM_KINDS][STACK_DEPTH];
    int unsigned     stack_levels [bpm_pkg::NUM_KINDS];
    logic [15:0]     next_token_idx;
    t_bracket_result pending_results [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        calm = 1'b0;
    logic        hold_tog = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic clear_matcher();
        for (int k = 0; k < bpm_pkg::NUM_KINDS; k++) stack_levels[k] = 0;
        next_token_idx = '0;
    endtask

    function automatic t_bracket_result make_result(input logic [1:0] kind,
                                                    input logic [2:0] ev,
                                                    input logic [15:0] oi,
                                                    input logic [15:0] ci);
        t_bracket_result r;
        r.kind = kind;
        r.ev = ev;
        r.open_idx = oi;
        r.close_idx = ci;
        r.last = 1'b0;
        return r;
    endfunction

    // work out the results of one accepted beat and queue them
    task automatic match_brackets(input logic mode, input logic single, input logic [7:0] ch);
        t_bracket_result found [$];
        logic [15:0] idx;
        if (mode == MODE_FLUSH) begin
            for (int k = 0; k < bpm_pkg::NUM_KINDS; k++) begin
                while (stack_levels[k] > 0) begin
                    stack_levels[k]--;
                    if (found.size() < bpm_pkg::RESULT_CAP - 1 && stack_levels[k] < STACK_DEPTH)
                        found.push_back(make_result(k[1:0], bpm_pkg::EV_UNOPEN,
                                                    open_stacks[k][stack_levels[k]], '0));
                end
            end
            found.push_back(make_result(bpm_pkg::KIND_PAREN, bpm_pkg::EV_END, '0, '0));
            clear_matcher();
        end else begin
            idx = next_token_idx;
            next_token_idx = next_token_idx + 16'd1;
            if (single) begin
                for (int k = 0; k < bpm_pkg::NUM_KINDS; k++) begin
                    if (ch == bracket_codes[2*k]) begin
                        if (stack_levels[k] < STACK_DEPTH) begin
                            open_stacks[k][stack_levels[k]] = idx;
                            stack_levels[k]++;
                        end else begin
                            found.push_back(make_result(k[1:0], bpm_pkg::EV_OVERFLOW, '0, idx));
                        end
                    end else if (ch == bracket_codes[2*k+1]) begin
                        if (stack_levels[k] == 0) begin
                            found.push_back(make_result(k[1:0], bpm_pkg::EV_UNCLOSE, '0, idx));
                        end else begin
                            stack_levels[k]--;
                            found.push_back(make_result(k[1:0], bpm_pkg::EV_PAIR,
                                                        open_stacks[k][stack_levels[k]], idx));
                        end
                    end
                end
            end
        end
        if (found.size() > 0) found[found.size()-1].last = 1'b1;
        foreach (found[i]) pending_results.push_back(found[i]);
    endtask

    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_bracket_result want;
        t_bracket_result got;
        if (i_rst_n && m_valid && m_ready) begin
            got.kind = m_tdata[1:0];
            got.ev = m_tdata[4:2];
            got.open_idx = m_tdata[20:5];
            got.close_idx = m_tdata[36:21];
            got.last = m_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.ev != want.ev)
                    report_mismatch($sformatf("event %0d, want %0d", got.ev, want.ev));
                if (got.open_idx != want.open_idx)
                    report_mismatch($sformatf("open index %0d, want %0d",
                                              got.open_idx, want.open_idx));
                if (got.close_idx != want.close_idx)
                    report_mismatch($sformatf("close index %0d, want %0d",
                                              got.close_idx, want.close_idx));
                if (got.last != want.last)
                    report_mismatch($sformatf("tlast %0b, want %0b", got.last, want.last));
            end
        end
    end

    // leaves tvalid high on return, so back-to-back beats need not drop it in between
    task automatic send_beat(input logic mode, input logic single, input logic [7:0] ch);
        while (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {7'd0, ch, single};
        do @(posedge i_clk); while (!s_ready);
        match_brackets(mode, single, ch);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_beat(MODE_TOKEN, 1'b1, ch);
    endtask

    // flush with junk in the ignored fields
    task automatic send_flush();
        send_beat(MODE_FLUSH, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_codes(input logic [bpm_pkg::NUM_CFG_REGS-1:0][7:0] codes);
        for (int r = 0; r < bpm_pkg::NUM_CFG_REGS; r++) begin
            cfg_we <= 1'b1;
            cfg_idx <= 3'(r);
            cfg_data <= codes[r];
            @(posedge i_clk);
            bracket_codes[r] = codes[r];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_bracket();
        int unsigned k;
        int unsigned p_open;
        k = $urandom_range(bpm_pkg::NUM_KINDS - 1);
        if (stack_levels[k] == 0) p_open = 80;
        else if (stack_levels[k] >= STACK_DEPTH - 2) p_open = 30;
        else p_open = 55;
        if ($urandom_range(99) < p_open) send_char(bracket_codes[2*k]);
        else send_char(bracket_codes[2*k+1]);
    endtask

    task automatic send_random_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) send_char(8'($urandom_range(255)));
        else if (r < 14) send_beat(MODE_TOKEN, 1'b0, 8'($urandom_range(255)));
        else if (r < 17) send_flush();
        else send_random_bracket();
    endtask

    task automatic test_basic_pairs();
        send_char(CH_LPAREN);
        send_char(CH_LSQUARE);
        send_char(CH_LBRACE);
        send_char(CH_RBRACE);
        send_char(CH_RSQUARE);
        send_char(CH_RPAREN);
        send_char(CH_RPAREN);
        send_beat(MODE_TOKEN, 1'b0, CH_LPAREN);
        send_char(CH_LETTER_A);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(CH_LSQUARE);
        send_char(CH_LPAREN);
        send_char(CH_LBRACE);
        send_beat(MODE_TOKEN, 1'b0, CH_RPAREN);
        send_flush();
        send_flush();
        wait_idle();
    endtask

    task automatic test_overflow();
        for (int i = 0; i <= STACK_DEPTH; i++) send_char(CH_LPAREN);
        send_char(CH_LPAREN);
        send_char(CH_RPAREN);
        send_flush();
        wait_idle();
    endtask

    task automatic test_shared_codes();
        logic [bpm_pkg::NUM_CFG_REGS-1:0][7:0] codes;
        // two kinds share codes at the extremes, braces open and close alike
        codes[REG_PAREN_OPEN] = 8'h00;
        codes[REG_PAREN_CLOSE] = 8'hFF;
        codes[REG_SQUARE_OPEN] = 8'h00;
        codes[REG_SQUARE_CLOSE] = 8'hFF;
        codes[REG_BRACE_OPEN] = 8'h7F;
        codes[REG_BRACE_CLOSE] = 8'h7F;
        set_codes(codes);
        send_char(8'h00);
        send_char(8'h7F);
        send_char(8'h7F);
        send_char(8'hFF);
        send_char(8'hFF);
        send_beat(MODE_TOKEN, 1'b0, 8'h00);
        send_flush();
        wait_idle();
        // one code opens one kind and closes another
        codes[REG_PAREN_OPEN] = 8'h5A;
        codes[REG_PAREN_CLOSE] = 8'hA5;
        codes[REG_SQUARE_OPEN] = 8'hA5;
        codes[REG_SQUARE_CLOSE] = 8'h5A;
        codes[REG_BRACE_OPEN] = 8'hFF;
        codes[REG_BRACE_CLOSE] = 8'h00;
        set_codes(codes);
        send_char(8'h5A);
        send_char(8'hA5);
        send_char(8'hA5);
        send_char(8'h5A);
        send_char(8'h00);
        send_char(8'hFF);
        send_flush();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [bpm_pkg::NUM_CFG_REGS-1:0][7:0] codes;
        for (int round = 0; round < 4; round++) begin
            case (round)
                0: codes = bpm_pkg::CHAR_RESET;
                1: for (int r = 0; r < bpm_pkg::NUM_CFG_REGS; r++) codes[r] = 8'($urandom_range(255));
                2: begin
                    codes = bpm_pkg::CHAR_RESET;
                    codes[REG_PAREN_OPEN] = 8'h00;
                    codes[REG_BRACE_CLOSE] = 8'hFF;
                end
                default: codes = bpm_pkg::CHAR_RESET;
            endcase
            set_codes(codes);
            calm <= (round == 2);
            for (int i = 0; i < 30; i++) send_random_item();
            send_flush();
            wait_idle();
        end
        calm <= 1'b0;
    endtask

    task automatic test_backpressure();
        hold_tog <= ~hold_tog;
        for (int i = 0; i < 30; i++) send_random_bracket();
        for (int i = 0; i < 10; i++) send_char(CH_LSQUARE);
        send_flush();
        for (int i = 0; i < 10; i++) send_random_bracket();
        wait_idle();
    endtask

    initial begin
        for (int r = 0; r < bpm_pkg::NUM_CFG_REGS; r++) bracket_codes[r] = bpm_pkg::CHAR_RESET[r];
        clear_matcher();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_pairs();
        test_overflow();
        test_shared_codes();
        test_random_traffic();
        test_backpressure();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
